>>> design/rmf_pkg.sv
// Shared types, constants and helpers for the mesh relay filter.
package rmf_pkg;

	localparam int OP_W       = 2;
	localparam int SEQ_W      = 16;
	localparam int HOP_W      = 8;
	localparam int ID_W       = 16;
	localparam int TYPE_W     = 8;
	localparam int DLY_W      = 16;
	localparam int TICK_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int DIV_STEPS   = DLY_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [DLY_W-1:0]  LFSR_SEED = 16'hACE1;
	localparam logic [DLY_W-1:0]  LFSR_MASK = 16'hB400;

	localparam logic              RST_RELAY_ENABLE = 1'b0;
	localparam logic [ID_W-1:0]   RST_OWN_ID       = 16'd0;
	localparam logic [TYPE_W-1:0] RST_ACK_TYPE     = 8'd1;
	localparam logic [DLY_W-1:0]  RST_MIN_DELAY    = 16'd100;
	localparam logic [DLY_W-1:0]  RST_DELAY_SPAN   = 16'd400;

	typedef enum logic [OP_W-1:0] {
		OP_PACKET = 2'd0,
		OP_TICK   = 2'd1,
		OP_CANCEL = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RELAY_ENABLE = 3'd0,
		CFG_OWN_ID       = 3'd1,
		CFG_ACK_TYPE     = 3'd2,
		CFG_MIN_DELAY    = 3'd3,
		CFG_DELAY_SPAN   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic              relay_enable;
		logic [ID_W-1:0]   own_id;
		logic [TYPE_W-1:0] ack_type;
		logic [DLY_W-1:0]  min_delay;
		logic [DLY_W-1:0]  delay_span;
	} cfg_t;

	// Classified item handed from front to back; hop is already incremented.
	typedef struct packed {
		op_t              op;
		logic             pkt_ok;
		logic [SEQ_W-1:0] seq;
		logic [HOP_W-1:0] hop;
	} job_t;

	typedef struct packed {
		logic             accepted;
		logic             send_now;
		logic [SEQ_W-1:0] out_seq;
		logic [HOP_W-1:0] out_hop;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_sts_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MATCH,
		F_DECIDE
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} back_state_t;

	// Galois LFSR, right shift
	function automatic logic [DLY_W-1:0] lfsr_next(input logic [DLY_W-1:0] v);
		logic [DLY_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_MASK;
		end
		return s;
	endfunction

endpackage

>>> design/rmf_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface rmf_item_if;
	import rmf_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [SEQ_W-1:0]  seq_num;
	logic [HOP_W-1:0]  hop_count;
	logic [HOP_W-1:0]  max_hop;
	logic [TYPE_W-1:0] msg_type;
	logic [ID_W-1:0]   source_id;
	modport source (output valid, opcode, seq_num, hop_count, max_hop, msg_type, source_id,
		input ready);
	modport sink (input valid, opcode, seq_num, hop_count, max_hop, msg_type, source_id,
		output ready);
endinterface

interface rmf_result_if;
	import rmf_pkg::*;
	logic             valid;
	logic             ready;
	logic             accepted;
	logic             send_now;
	logic [SEQ_W-1:0] out_seq;
	logic [HOP_W-1:0] out_hop;
	modport source (output valid, accepted, send_now, out_seq, out_hop, input ready);
	modport sink (input valid, accepted, send_now, out_seq, out_hop, output ready);
endinterface

interface rmf_cfg_if;
	import rmf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/rmf_front.sv
// Front end: takes items, checks the duplicate cache and classifies packets.
module rmf_front #(
	parameter int CACHE_DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	rmf_item_if.sink       item,
	input  rmf_pkg::cfg_t  cfg_bits,
	input  rmf_pkg::queue_sts_t q_sts,
	output logic           push,
	output rmf_pkg::job_t  job
);
	import rmf_pkg::*;

	localparam int SLOT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_DEPTH - 1);

	front_state_t state_q, state_d;

	logic [SEQ_W-1:0]       seen_q [CACHE_DEPTH];
	logic [SLOT_W-1:0]      slot_q;
	logic [CACHE_DEPTH-1:0] match_q;

	logic [OP_W-1:0]   op_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [HOP_W-1:0]  hop_q;
	logic [HOP_W-1:0]  max_q;
	logic [TYPE_W-1:0] type_q;
	logic [ID_W-1:0]   src_q;

	logic pkt_ok;
	logic take;

	assign pkt_ok = (op_q == OP_PACKET) && cfg_bits.relay_enable
		&& (src_q != cfg_bits.own_id) && !(|match_q)
		&& (hop_q < max_q) && (type_q != cfg_bits.ack_type);

	assign take = item.valid && item.ready;

	assign job.op     = op_t'(op_q);
	assign job.pkt_ok = pkt_ok;
	assign job.seq    = seq_q;
	assign job.hop    = hop_q + HOP_W'(1);

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		push       = 1'b0;
		case (state_q)
			F_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = F_MATCH;
				end
			end
			F_MATCH: begin
				state_d = F_DECIDE;
			end
			F_DECIDE: begin
				if (!q_sts.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= item.opcode;
			seq_q  <= item.seq_num;
			hop_q  <= item.hop_count;
			max_q  <= item.max_hop;
			type_q <= item.msg_type;
			src_q  <= item.source_id;
		end
		if (state_q == F_MATCH) begin
			for (int i = 0; i < CACHE_DEPTH; i++) begin
				match_q[i] <= (seen_q[i] == seq_q);
			end
		end
	end

	// cache ring, oldest entry overwritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_DEPTH; i++) begin
				seen_q[i] <= '0;
			end
			slot_q <= '0;
		end else if (push && pkt_ok) begin
			seen_q[slot_q] <= seq_q;
			slot_q         <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
		end
	end

endmodule

>>> design/rmf_queue.sv
// Short FIFO of classified jobs between front and back.
module rmf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  rmf_pkg::queue_ctl_t ctl,
	input  rmf_pkg::job_t       wr_job,
	output rmf_pkg::job_t       rd_job,
	output rmf_pkg::queue_sts_t sts
);
	import rmf_pkg::*;

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign sts.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign sts.empty = (count_q == '0);
	assign rd_job    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !sts.full || ctl.pop)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !sts.empty)
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

>>> design/rmf_back.sv
// Back end: backoff divider, held relay, tick countdown and result register.
module rmf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rmf_pkg::cfg_t       cfg_bits,
	input  rmf_pkg::job_t       job,
	input  rmf_pkg::queue_sts_t q_sts,
	output logic                pop,
	rmf_result_if.source        result
);
	import rmf_pkg::*;

	back_state_t state_q, state_d;

	job_t                 job_q;
	logic [DLY_W-1:0]     lfsr_q;
	logic [DLY_W-1:0]     dvd_q;
	logic [DLY_W-1:0]     rem_q;
	logic [DLY_W-1:0]     span_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic              held_valid_q;
	logic [SEQ_W-1:0]  held_seq_q;
	logic [HOP_W-1:0]  held_hop_q;
	logic [TICK_W-1:0] ticks_q;

	logic    res_valid_q;
	result_t res_q;
	result_t res_d;

	logic              slot_free;
	logic              emit;
	logic              job_ok;
	logic [DLY_W-1:0]  lfsr_nx;
	logic [DLY_W:0]    rem_sh;
	logic [DLY_W:0]    rem_sub;
	logic              rem_ge;
	logic [TICK_W-1:0] tdec;
	logic [TICK_W-1:0] backoff;

	assign slot_free = !res_valid_q || result.ready;
	assign job_ok    = (job.op == OP_PACKET) && job.pkt_ok;
	assign lfsr_nx   = lfsr_next(lfsr_q);

	// restoring division, one quotient bit a cycle
	assign rem_sh  = {rem_q, dvd_q[DLY_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, span_q};
	assign rem_sub = rem_sh - {1'b0, span_q};

	assign tdec    = (ticks_q != '0) ? ticks_q - TICK_W'(1) : ticks_q;
	assign backoff = {1'b0, cfg_bits.min_delay} + {1'b0, rem_q};

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_sts.empty) begin
					pop     = 1'b1;
					state_d = job_ok ? B_DIV : B_EMIT;
				end
			end
			B_DIV: begin
				if (cnt_q == '0) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		res_d = '0;
		case (job_q.op)
			OP_PACKET: begin
				res_d.accepted = job_q.pkt_ok;
			end
			OP_TICK: begin
				if (held_valid_q && tdec == '0) begin
					res_d.send_now = 1'b1;
					res_d.out_seq  = held_seq_q;
					res_d.out_hop  = held_hop_q;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			lfsr_q       <= LFSR_SEED;
			held_valid_q <= 1'b0;
			held_seq_q   <= '0;
			held_hop_q   <= '0;
			ticks_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && job_ok) begin
				lfsr_q <= lfsr_nx;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (emit) begin
				case (job_q.op)
					OP_PACKET: begin
						if (job_q.pkt_ok) begin
							held_valid_q <= 1'b1;
							held_seq_q   <= job_q.seq;
							held_hop_q   <= job_q.hop;
							ticks_q      <= backoff;
						end
					end
					OP_TICK: begin
						if (held_valid_q) begin
							ticks_q <= tdec;
							if (tdec == '0) begin
								held_valid_q <= 1'b0;
							end
						end
					end
					OP_CANCEL: begin
						held_valid_q <= 1'b0;
						ticks_q      <= '0;
					end
					default: begin
						held_valid_q <= held_valid_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= job;
			dvd_q  <= lfsr_nx;
			rem_q  <= '0;
			span_q <= (cfg_bits.delay_span == '0) ? DLY_W'(1) : cfg_bits.delay_span;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (state_q == B_DIV) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_ge ? rem_sub[DLY_W-1:0] : rem_sh[DLY_W-1:0];
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.accepted = res_q.accepted;
	assign result.send_now = res_q.send_now;
	assign result.out_seq  = res_q.out_seq;
	assign result.out_hop  = res_q.out_hop;

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV && cnt_q == '0) |=> state_q == B_EMIT)
		else $error("divider did not finish after its last step");
	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.accepted) |=> held_valid_q)
		else $error("accepted packet left no held relay");
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.send_now) |-> (result.out_seq == '0 && result.out_hop == '0))
		else $error("relay fields set without a send");

endmodule

>>> design/mesh_relay_filter_backoff.sv
// Flow: the front registers a beat, checks the duplicate cache, decides and enqueues it;
// the back pops the job and runs an accepted packet through the 16-step backoff divider.
// The front takes a new beat only once the last is enqueued, and waits while the 2-entry
// job queue is full; the back pops a new job only after emitting the previous result.
// Reset (arst_n low, asynchronous): registers to their defaults, duplicate cache to zeros,
// LFSR to 0xACE1, no relay held, queue and result register empty.
module mesh_relay_filter_backoff #(
	parameter int CACHE_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	rmf_item_if.sink     item,
	rmf_result_if.source result,
	rmf_cfg_if.sink      cfg
);
	import rmf_pkg::*;

	cfg_t       cfg_q;
	job_t       push_job;
	job_t       pop_job;
	queue_ctl_t q_ctl;
	queue_sts_t q_sts;
	logic       front_push;
	logic       back_pop;

	// Configuration writes are always taken; out-of-range indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relay_enable <= RST_RELAY_ENABLE;
			cfg_q.own_id       <= RST_OWN_ID;
			cfg_q.ack_type     <= RST_ACK_TYPE;
			cfg_q.min_delay    <= RST_MIN_DELAY;
			cfg_q.delay_span   <= RST_DELAY_SPAN;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_RELAY_ENABLE: cfg_q.relay_enable <= cfg.data[0];
				CFG_OWN_ID:       cfg_q.own_id       <= cfg.data[ID_W-1:0];
				CFG_ACK_TYPE:     cfg_q.ack_type     <= cfg.data[TYPE_W-1:0];
				CFG_MIN_DELAY:    cfg_q.min_delay    <= cfg.data[DLY_W-1:0];
				CFG_DELAY_SPAN:   cfg_q.delay_span   <= cfg.data[DLY_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Front: accept beat, register per-entry cache matches, then decide and
	// enqueue. Cache and write slot live here so the next packet sees this
	// one's entry regardless of how far behind the back end is.
	rmf_front #(
		.CACHE_DEPTH(CACHE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_bits (cfg_q),
		.q_sts    (q_sts),
		.push     (front_push),
		.job      (push_job)
	);

	assign q_ctl.push = front_push;
	assign q_ctl.pop  = back_pop;

	rmf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.wr_job (push_job),
		.rd_job (pop_job),
		.sts    (q_sts)
	);

	// Back: owns LFSR, held relay and countdown; one output register keeps
	// a finished result waiting while the front keeps filling the queue.
	rmf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_bits (cfg_q),
		.job      (pop_job),
		.q_sts    (q_sts),
		.pop      (back_pop),
		.result   (result)
	);

endmodule
